// File: hdl/mthc_pkg.sv
// Shared types, keyword tables and byte helpers for the media type header classifier.
// Has no dependencies; every other file of the block imports it.
package mthc_pkg;

  localparam int KW_NUM     = 5;
  localparam int KW_MAX_LEN = 21;
  localparam int LEN_W      = 5;

  typedef logic [KW_MAX_LEN*8-1:0] kw_str_t;

  typedef enum logic [2:0] {
    CLS_UNKNOWN   = 3'd0,
    CLS_FHIR_JSON = 3'd1,
    CLS_FHIR_XML  = 3'd2,
    CLS_JSON      = 3'd3,
    CLS_XML       = 3'd4
  } class_t;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_MEDIA = 2'd1,
    PH_TRAIL = 2'd2,
    PH_PARAM = 2'd3
  } phase_t;

  // Keyword text is right-justified: character i of a keyword of length L
  // sits at byte position L-1-i.
  localparam kw_str_t KW_TEXT [KW_NUM] = '{
    kw_str_t'("application/fhir+json"),
    kw_str_t'("application/fhir+xml"),
    kw_str_t'("application/json"),
    kw_str_t'("application/xml"),
    kw_str_t'("text/xml")
  };
  localparam logic [LEN_W-1:0] KW_LEN [KW_NUM] = '{5'd21, 5'd20, 5'd16, 5'd15, 5'd8};
  localparam class_t KW_CLASS [KW_NUM] = '{CLS_FHIR_JSON, CLS_FHIR_XML, CLS_JSON,
                                           CLS_XML, CLS_XML};

  localparam logic [LEN_W-1:0] LEN_MAX   = 5'd31;
  localparam logic [7:0]       CH_COMMA  = 8'h2C;
  localparam logic [7:0]       CH_SEMI   = 8'h3B;
  localparam logic [7:0]       CH_STAR   = 8'h2A;
  localparam logic [7:0]       CH_SLASH  = 8'h2F;
  localparam logic [2:0]       WILD_LEN  = 3'd3;

  // Broadcast from the part tracker to every keyword cell for one beat.
  typedef struct packed {
    logic             step;      // a beat is accepted this cycle
    logic             feed;      // the byte extends the media type
    logic             kill;      // whitespace inside the media type
    logic             finish;    // the part ends at this beat
    logic [7:0]       lc;        // lower-cased byte
    logic [LEN_W-1:0] len;       // media type length before the byte
    logic [LEN_W-1:0] len_feed;  // media type length after the byte
  } bcast_t;

  // Priority token handed from cell to cell.
  typedef struct packed {
    logic   open;  // no earlier keyword has claimed the part
    class_t cls;
  } chain_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'h20 : c;
  endfunction

endpackage

// File: hdl/media_type_header_classifier.sv
// Top level of the media type header classifier: part tracker, wildcard tracker,
// keyword cell chain and output register. Depends on mthc_pkg and mthc_kw_cell.
//
//   channel | ports                      | beat carries
//   --------+----------------------------+-----------------------------------------
//   input   | in_tvalid/tready/tdata/... | one header byte, valid flag, last flag
//   output  | out_tvalid/tready/tdata    | one media class code per header
//
// Beats are handled combinationally, so one beat per cycle is sustained unless the
// output stalls; a header's result is registered in the cycle after its last beat.
// Reset is synchronous and active low; it clears all control state.
// The output register is a single stage: a new beat is accepted while a waiting
// result is taken in the same cycle, and the input stalls only while a result is
// held by a low out_tready.
module media_type_header_classifier
  import mthc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] header_byte
  input  logic       in_tuser,   // [0] byte_valid
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] media_class, [7:3] zero
);

  // Part state: where we are inside the current comma-separated part.
  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  // Decision and wildcard state for the whole header.
  logic             decided_r, decided_nxt;
  class_t           dec_class_r, dec_class_nxt;
  logic             wc_alive_r, wc_alive_nxt;
  logic [2:0]       wc_len_r, wc_len_nxt;
  logic             has_r, has_nxt;
  logic             trail_r, trail_nxt;

  // Result register.
  logic             out_valid_r;
  class_t           out_class_r;
  class_t           final_class;

  logic             in_fire;
  logic [7:0]       c;
  logic             v;
  logic             ws;
  logic             comma;
  logic             semi;
  logic             feed;
  logic             kill;
  logic             finish;
  logic [LEN_W-1:0] len_feed;
  logic             hit;
  logic             wild_ok;
  logic [7:0]       wild_char;
  bcast_t           bcast;
  chain_t           chain [KW_NUM+1];

  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;
  assign c         = in_tdata;
  assign v         = in_tuser;
  assign ws        = is_ws(c);
  assign comma     = v && (c == CH_COMMA);
  assign semi      = (c == CH_SEMI);

  // The part ends at a comma or at the last beat. At a comma nothing is fed,
  // so the cells evaluate the part as it stood before the comma.
  assign finish = in_fire && (comma || in_tlast);

  // Phase state machine: next state.
  always_comb begin
    phase_nxt = phase_r;
    if (v && !comma) begin
      case (phase_r)
        PH_LEAD: begin
          if (semi) phase_nxt = PH_PARAM;
          else if (!ws) phase_nxt = PH_MEDIA;
        end
        PH_MEDIA: begin
          if (ws) phase_nxt = PH_TRAIL;
          else if (semi) phase_nxt = PH_PARAM;
        end
        PH_TRAIL: begin
          if (semi) phase_nxt = PH_PARAM;
          else if (!ws) phase_nxt = PH_MEDIA;
        end
        PH_PARAM: phase_nxt = PH_PARAM;
        default:  phase_nxt = PH_LEAD;
      endcase
    end
    if (comma || in_tlast) phase_nxt = PH_LEAD;
  end

  // Phase state machine: outputs. A character after inner whitespace kills
  // every keyword for the rest of the part.
  always_comb begin
    feed = 1'b0;
    kill = 1'b0;
    if (v && !comma && !ws && !semi) begin
      case (phase_r)
        PH_LEAD:  feed = 1'b1;
        PH_MEDIA: feed = 1'b1;
        PH_TRAIL: kill = 1'b1;
        PH_PARAM: feed = 1'b0;
        default:  feed = 1'b0;
      endcase
    end
  end

  assign len_feed = (feed && (len_r != LEN_MAX)) ? len_r + 5'd1 : len_r;
  assign len_nxt  = (comma || in_tlast) ? '0 : len_feed;

  assign bcast.step     = in_fire;
  assign bcast.feed     = feed;
  assign bcast.kill     = kill;
  assign bcast.finish   = comma || in_tlast;
  assign bcast.lc       = to_lower(c);
  assign bcast.len      = len_r;
  assign bcast.len_feed = len_feed;

  // The token enters the chain only when a part ends and nothing is decided yet;
  // the first cell that matches closes it and puts its class on it.
  assign chain[0].open = finish & ~decided_r;
  assign chain[0].cls  = CLS_UNKNOWN;

  for (genvar k = 0; k < KW_NUM; k++) begin : g_cell
    mthc_kw_cell #(
      .IDX(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bcast    (bcast),
      .chain_in (chain[k]),
      .chain_out(chain[k+1])
    );
  end

  assign hit = chain[0].open & ~chain[KW_NUM].open;

  // Wildcard tracker: follows the whole trimmed header against "*/*".
  assign wild_char = (wc_len_r == 3'd1) ? CH_SLASH : CH_STAR;
  assign wild_ok   = (wc_len_r < WILD_LEN) && (c == wild_char);

  always_comb begin
    wc_alive_nxt = wc_alive_r;
    wc_len_nxt   = wc_len_r;
    has_nxt      = has_r;
    trail_nxt    = trail_r;
    if (v) begin
      if (ws) begin
        if (has_r) trail_nxt = 1'b1;
      end else begin
        if (has_r && trail_r) wc_alive_nxt = 1'b0;
        if (wild_ok) wc_len_nxt = wc_len_r + 3'd1;
        else wc_alive_nxt = 1'b0;
        has_nxt   = 1'b1;
        trail_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    decided_nxt   = decided_r | hit;
    dec_class_nxt = decided_r ? dec_class_r : (hit ? chain[KW_NUM].cls : dec_class_r);
    if (!has_nxt || (wc_alive_nxt && (wc_len_nxt == WILD_LEN))) final_class = CLS_FHIR_JSON;
    else if (decided_nxt) final_class = dec_class_nxt;
    else final_class = CLS_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      len_r       <= '0;
      decided_r   <= 1'b0;
      dec_class_r <= CLS_UNKNOWN;
      wc_alive_r  <= 1'b1;
      wc_len_r    <= '0;
      has_r       <= 1'b0;
      trail_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      if (in_tlast) begin
        // Header done: everything returns to its reset value.
        decided_r   <= 1'b0;
        dec_class_r <= CLS_UNKNOWN;
        wc_alive_r  <= 1'b1;
        wc_len_r    <= '0;
        has_r       <= 1'b0;
        trail_r     <= 1'b0;
      end else begin
        decided_r   <= decided_nxt;
        dec_class_r <= dec_class_nxt;
        wc_alive_r  <= wc_alive_nxt;
        wc_len_r    <= wc_len_nxt;
        has_r       <= has_nxt;
        trail_r     <= trail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      out_class_r <= final_class;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_class_r};

  // A media type phase always follows at least one media type byte.
  a_media_len : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MEDIA |-> len_r != '0)
    else $error("media phase with empty media type");

  // A decision holds until the header ends.
  a_decided_holds : assert property (@(posedge clk) disable iff (!rst_n)
    decided_r && !(in_fire && in_tlast) |=> decided_r)
    else $error("decision dropped inside a header");

  // The last beat clears the per-header state.
  a_last_clears : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> !decided_r && !has_r && wc_len_r == '0 && len_r == '0)
    else $error("header state not cleared after last beat");

  // A waiting result is never overwritten while the output stalls.
  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_fire)
    else $error("beat accepted while result is held");

endmodule

// File: hdl/mthc_kw_cell.sv
// One keyword cell of the matcher chain: tracks whether its keyword still matches.
// Depends on mthc_pkg for the keyword tables and the broadcast and chain structs.
module mthc_kw_cell
  import mthc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  bcast_t bcast,
  input  chain_t chain_in,
  output chain_t chain_out
);

  localparam logic [LEN_W-1:0] MY_LEN = KW_LEN[IDX];
  localparam logic [255:0]     TEXT_W = {{(256 - KW_MAX_LEN*8){1'b0}}, KW_TEXT[IDX]};

  logic             alive_r;
  logic             alive_nxt;
  logic             alive_feed;
  logic             miss;
  logic             match;
  logic [LEN_W-1:0] pos;
  logic [7:0]       kw_char;

  // Position wraps for lengths beyond the keyword; the length test covers that.
  assign pos        = MY_LEN - 5'd1 - bcast.len;
  assign kw_char    = TEXT_W[{pos, 3'b000} +: 8];
  assign miss       = (bcast.len >= MY_LEN) || (kw_char != bcast.lc);
  assign alive_feed = alive_r & ~(bcast.feed & miss) & ~bcast.kill;
  assign match      = alive_feed && (bcast.len_feed == MY_LEN);
  assign alive_nxt  = bcast.finish ? 1'b1 : alive_feed;

  assign chain_out.open = chain_in.open & ~match;
  assign chain_out.cls  = (chain_in.open && match) ? KW_CLASS[IDX] : chain_in.cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b1;
    end else if (bcast.step) begin
      alive_r <= alive_nxt;
    end
  end

endmodule
